FILE: src/hgc_pkg.sv
// ----------------------------------------------------------------------------
// hgc_pkg: shared types and constants of the geofence classifier
// Angle scaling, CORDIC word sizes, the arctangent table, register and
// alarm codes, and the structs that pass between the top level and the
// datapath.
// ----------------------------------------------------------------------------
package hgc_pkg;

  // Number of CORDIC iterations in each rotation and vectoring pipeline.
  localparam int CORDIC_STEPS = 24;

  // CORDIC word: Q.30 values with headroom for gain and sign.
  localparam int CW = 34;
  // Square root: radicand up to 2^60, root up to 2^30.
  localparam int RW  = 61;
  localparam int TW  = 62;
  localparam int RTW = 31;
  localparam int SQ  = 31;
  // Quotient bits of the residual correction and the divider word.
  localparam int QW = 40 - CORDIC_STEPS;
  localparam int DW = 64;
  // Central angle width after correction.
  localparam int TAW = 33;

  // Angles in microdegrees.
  localparam int FULL_TURN_UDEG    = 360000000;
  localparam int HALF_TURN_UDEG    = 180000000;
  localparam int QUARTER_TURN_UDEG = 90000000;

  // Radians per half-microdegree in Q.62, split for two narrow products.
  localparam logic [63:0] RAD_K = 64'd40244552545;
  localparam logic [17:0] RAD_K_HI = 18'(RAD_K >> 18);
  localparam logic [17:0] RAD_K_LO = RAD_K[17:0];

  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic [23:0] DIAMETER_M = 24'd12742000;
  localparam logic [24:0] MAX_DISTANCE_M = 25'd20015087;

  // Configuration register indexes.
  localparam logic [1:0] REG_NEAR_LIMIT = 2'd0;
  localparam logic [1:0] REG_FAR_LIMIT  = 2'd1;

  // Alarm levels.
  localparam logic [1:0] ALARM_NONE = 2'd0;
  localparam logic [1:0] ALARM_NEAR = 2'd1;
  localparam logic [1:0] ALARM_FAR  = 2'd2;

  // One input item.
  typedef struct packed {
    logic              armed;
    logic signed [27:0] last_lat;
    logic signed [28:0] last_lng;
    logic signed [27:0] cur_lat;
    logic signed [28:0] cur_lng;
  } hgc_item_t;

  // Control that travels alongside the datapath.
  typedef struct packed {
    logic vld;
    logic armed;
    logic neg_c1;
    logic neg_c2;
  } hgc_side_t;

  // Result leaving the datapath.
  typedef struct packed {
    logic        vld;
    logic        armed;
    logic [24:0] dist_m;
  } hgc_res_t;

  // Arctangent of 2^-i in Q.30, rounded.
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
    logic signed [CW-1:0] v;
    v = '0;
    case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      default: begin
        if (idx < 31) v[30-idx] = 1'b1;
        else v = 34'sd1;
      end
    endcase
    return v;
  endfunction

endpackage

FILE: src/hgc_datapath.sv
// ----------------------------------------------------------------------------
// hgc_datapath: haversine distance pipeline
// Angle reduction, four rotation CORDICs, the haversine products, two
// bit-serial square roots, a vectoring CORDIC, a pipelined divider for the
// residual and the final scaling to metres. Every stage moves on en.
// ----------------------------------------------------------------------------
module hgc_datapath import hgc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      item_vld,
  input  hgc_item_t item,
  output hgc_res_t  res
);

  localparam int N    = CORDIC_STEPS;
  localparam int J_C1 = 4 + N;
  localparam int LAT  = 13 + 2 * N + SQ + QW;

  // Wrap a difference into a half turn either way and take its magnitude.
  function automatic logic [27:0] wrap_abs(input logic signed [30:0] v);
    logic signed [30:0] r;
    r = v;
    if (v >= 31'(HALF_TURN_UDEG)) r = v - 31'(FULL_TURN_UDEG);
    else if (v < -31'(HALF_TURN_UDEG)) r = v + 31'(FULL_TURN_UDEG);
    if (r < 0) r = -r;
    return r[27:0];
  endfunction

  // Fold a latitude into the first quadrant; top bit flags a negated cosine.
  function automatic logic [28:0] cos_angle(input logic signed [27:0] lat);
    logic [27:0] a;
    logic [27:0] b;
    a = lat[27] ? 28'(-lat) : 28'(lat);
    b = 28'(HALF_TURN_UDEG) - a;
    if (a > 28'(QUARTER_TURN_UDEG)) return {1'b1, b[26:0], 1'b0};
    return {1'b0, a[26:0], 1'b0};
  endfunction

  // Side pipe: valid, armed and the cosine sign flags.
  hgc_side_t side_in;
  hgc_side_t side_r [1:LAT];
  logic [28:0] ca1, ca2;

  assign ca1 = cos_angle(item.last_lat);
  assign ca2 = cos_angle(item.cur_lat);

  always_comb begin
    side_in.vld    = item_vld;
    side_in.armed  = item.armed;
    side_in.neg_c1 = ca1[28];
    side_in.neg_c2 = ca2[28];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= LAT; j++) side_r[j] <= '0;
    end else if (en) begin
      side_r[1] <= side_in;
      for (int j = 2; j <= LAT; j++) side_r[j] <= side_r[j-1];
    end
  end

  // Stage 1: angles in half-microdegrees for the four lanes.
  // Lanes: 0 half latitude difference, 1 half longitude difference,
  // 2 and 3 the two latitudes for their cosines.
  logic [27:0] h_nxt [0:3];
  logic [27:0] h_r   [0:3];

  always_comb begin
    h_nxt[0] = wrap_abs(31'(item.cur_lat) - 31'(item.last_lat));
    h_nxt[1] = wrap_abs(31'(item.cur_lng) - 31'(item.last_lng));
    h_nxt[2] = ca1[27:0];
    h_nxt[3] = ca2[27:0];
  end

  always_ff @(posedge clk) begin
    if (en) h_r <= h_nxt;
  end

  // Stage 2: partial products of the radian conversion.
  logic [45:0] ph_nxt [0:3];
  logic [45:0] pl_nxt [0:3];
  logic [45:0] ph_r   [0:3];
  logic [45:0] pl_r   [0:3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ph_nxt[l] = h_r[l] * RAD_K_HI;
      pl_nxt[l] = h_r[l] * RAD_K_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
  end

  // Stage 3: Q.30 radians, seeding the rotation CORDICs.
  logic signed [CW-1:0] rx_r [0:N][0:3];
  logic signed [CW-1:0] ry_r [0:N][0:3];
  logic signed [CW-1:0] rz_r [0:N][0:3];
  logic signed [CW-1:0] z0_nxt [0:3];

  always_comb begin
    logic [63:0] sum;
    for (int l = 0; l < 4; l++) begin
      sum = {ph_r[l], 18'b0} + 64'(pl_r[l]);
      z0_nxt[l] = $signed({2'b00, sum[63:32]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        rx_r[0][l] <= INV_GAIN_Q30;
        ry_r[0][l] <= '0;
        rz_r[0][l] <= z0_nxt[l];
      end
    end
  end

  // Rotation CORDIC, one iteration per stage.
  for (genvar k = 0; k < N; k++) begin : g_rot
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;

      always_comb begin
        if (rz_r[k][l] >= 0) begin
          x_nxt = rx_r[k][l] - (ry_r[k][l] >>> k);
          y_nxt = ry_r[k][l] + (rx_r[k][l] >>> k);
          z_nxt = rz_r[k][l] - atan_q30(k);
        end else begin
          x_nxt = rx_r[k][l] + (ry_r[k][l] >>> k);
          y_nxt = ry_r[k][l] - (rx_r[k][l] >>> k);
          z_nxt = rz_r[k][l] + atan_q30(k);
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rx_r[k+1][l] <= x_nxt;
          ry_r[k+1][l] <= y_nxt;
          rz_r[k+1][l] <= z_nxt;
        end
      end
    end
  end

  // First-order correction with the residual angle: product stage.
  logic signed [63:0]   cm_nxt [0:3];
  logic signed [CW-1:0] cb_nxt [0:3];
  logic signed [63:0]   cm_r   [0:3];
  logic signed [CW-1:0] cb_r   [0:3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (l < 2) begin
        cm_nxt[l] = rz_r[N][l] * rx_r[N][l];
        cb_nxt[l] = ry_r[N][l];
      end else begin
        cm_nxt[l] = rz_r[N][l] * ry_r[N][l];
        cb_nxt[l] = rx_r[N][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm_r <= cm_nxt;
      cb_r <= cb_nxt;
    end
  end

  // Correction add, with the cosine sign restored.
  logic signed [CW-1:0] sc_nxt [0:3];
  logic signed [CW-1:0] sc_r   [0:3];

  always_comb begin
    logic signed [63:0] sh;
    logic               neg;
    for (int l = 0; l < 4; l++) begin
      sh = cm_r[l] >>> 30;
      neg = (l == 2) ? side_r[J_C1].neg_c1 : side_r[J_C1].neg_c2;
      if (l < 2) begin
        sc_nxt[l] = cb_r[l] + sh[CW-1:0];
      end else begin
        sc_nxt[l] = cb_r[l] - sh[CW-1:0];
        if (neg) sc_nxt[l] = -sc_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) sc_r <= sc_nxt;
  end

  // Haversine, first products: cosine product and squared sine.
  logic signed [63:0]   ccp_nxt, ss1_nxt;
  logic signed [63:0]   ccp_r, ss1_r;
  logic signed [CW-1:0] s2a_r;

  always_comb begin
    ccp_nxt = sc_r[2] * sc_r[3];
    ss1_nxt = sc_r[0] * sc_r[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ccp_r <= ccp_nxt;
      ss1_r <= ss1_nxt;
      s2a_r <= sc_r[1];
    end
  end

  // Haversine, second product: cosine product times the longitude sine.
  logic signed [63:0]   t2p_nxt;
  logic signed [63:0]   t2p_r, ss1b_r;
  logic signed [CW-1:0] s2b_r;

  always_comb begin
    logic signed [63:0] sh;
    sh = ccp_r >>> 30;
    t2p_nxt = $signed(sh[CW-1:0]) * s2a_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2p_r  <= t2p_nxt;
      ss1b_r <= ss1_r;
      s2b_r  <= s2a_r;
    end
  end

  // Haversine, third product: once more by the longitude sine.
  logic signed [63:0] t3p_nxt;
  logic signed [63:0] t3p_r, ss1c_r;

  always_comb begin
    logic signed [63:0] sh;
    sh = t2p_r >>> 30;
    t3p_nxt = $signed(sh[CW-1:0]) * s2b_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3p_r  <= t3p_nxt;
      ss1c_r <= ss1b_r;
    end
  end

  // Haversine sum, clamped to [0, 1], and its complement: square root seeds.
  // Lane 0 takes the haversine value, lane 1 its complement.
  localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;

  logic [RW-1:0]  rem_r  [0:SQ][0:1];
  logic [RTW-1:0] root_r [0:SQ][0:1];
  logic [RW-1:0]  hav_nxt;

  always_comb begin
    logic signed [63:0] hs;
    hs = ss1c_r + t3p_r;
    if (hs < 0) hav_nxt = '0;
    else if (hs > ONE_Q60) hav_nxt = ONE_Q60[RW-1:0];
    else hav_nxt = hs[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0][0]  <= hav_nxt;
      rem_r[0][1]  <= ONE_Q60[RW-1:0] - hav_nxt;
      root_r[0][0] <= '0;
      root_r[0][1] <= '0;
    end
  end

  // Square roots, one root bit per stage from the top.
  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    localparam int B = SQ - 1 - i;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RW-1:0]  rem_nxt;
      logic [RTW-1:0] root_nxt;

      always_comb begin
        logic [TW-1:0] trial;
        trial = (TW'(root_r[i][l]) << (B + 1)) + (TW'(1) << (2 * B));
        rem_nxt  = rem_r[i][l];
        root_nxt = root_r[i][l];
        if (TW'(rem_r[i][l]) >= trial) begin
          rem_nxt  = rem_r[i][l] - trial[RW-1:0];
          root_nxt = root_r[i][l] | (RTW'(1) << B);
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1][l]  <= rem_nxt;
          root_r[i+1][l] <= root_nxt;
        end
      end
    end
  end

  // Vectoring CORDIC from (complement root, haversine root).
  logic signed [CW-1:0] vx_r [1:N];
  logic signed [CW-1:0] vy_r [1:N];
  logic signed [CW-1:0] vz_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_vec
    logic signed [CW-1:0] xi, yi, zi;
    logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;

    if (k == 0) begin : g_first
      assign xi = $signed({3'b000, root_r[SQ][1]});
      assign yi = $signed({3'b000, root_r[SQ][0]});
      assign zi = '0;
    end else begin : g_next
      assign xi = vx_r[k];
      assign yi = vy_r[k];
      assign zi = vz_r[k];
    end

    always_comb begin
      if (yi >= 0) begin
        x_nxt = xi + (yi >>> k);
        y_nxt = yi - (xi >>> k);
        z_nxt = zi + atan_q30(k);
      end else begin
        x_nxt = xi - (yi >>> k);
        y_nxt = yi + (xi >>> k);
        z_nxt = zi - atan_q30(k);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vx_r[k+1] <= x_nxt;
        vy_r[k+1] <= y_nxt;
        vz_r[k+1] <= z_nxt;
      end
    end
  end

  // Divider set-up: magnitude of the residual scaled by 2^30 over x.
  logic [DW-1:0]        drem_r [0:QW];
  logic [QW-1:0]        dq_r   [0:QW];
  logic [CW-1:0]        dx_r   [0:QW];
  logic signed [CW-1:0] dz_r   [0:QW];
  logic                 dneg_r [0:QW];
  logic                 dok_r  [0:QW];

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] mag;
    if (en) begin
      mag = vy_r[N][CW-1] ? -vy_r[N] : vy_r[N];
      drem_r[0] <= {mag, 30'b0};
      dq_r[0]   <= '0;
      dx_r[0]   <= vx_r[N];
      dz_r[0]   <= vz_r[N];
      dneg_r[0] <= vy_r[N][CW-1];
      dok_r[0]  <= (vx_r[N] > 0);
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int S = QW - 1 - i;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    always_comb begin
      logic [DW-1:0] dv;
      dv = DW'(dx_r[i]) << S;
      rem_nxt = drem_r[i];
      q_nxt   = dq_r[i];
      if (drem_r[i] >= dv) begin
        rem_nxt = drem_r[i] - dv;
        q_nxt   = dq_r[i] | (QW'(1) << S);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[i+1] <= rem_nxt;
        dq_r[i+1]   <= q_nxt;
        dx_r[i+1]   <= dx_r[i];
        dz_r[i+1]   <= dz_r[i];
        dneg_r[i+1] <= dneg_r[i];
        dok_r[i+1]  <= dok_r[i];
      end
    end
  end

  // Central angle with the residual added; negative angles become zero.
  logic [TAW-1:0] t_nxt, t_r;

  always_comb begin
    logic signed [CW:0]   qs;
    logic signed [CW+1:0] ts;
    qs = $signed({{(CW + 1 - QW){1'b0}}, dq_r[QW]});
    if (dneg_r[QW]) qs = -qs;
    ts = (CW + 2)'(dz_r[QW]);
    if (dok_r[QW]) ts = ts + (CW + 2)'(qs);
    t_nxt = (ts < 0) ? '0 : ts[TAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) t_r <= t_nxt;
  end

  // Scale by the earth's diameter.
  logic [TAW+23:0] dp_nxt, dp_r;

  assign dp_nxt = t_r * DIAMETER_M;

  always_ff @(posedge clk) begin
    if (en) dp_r <= dp_nxt;
  end

  // Whole metres, clamped to half the circumference.
  logic [24:0] dist_nxt, dist_r;

  always_comb begin
    logic [TAW-7:0] d;
    d = dp_r[TAW+23:30];
    dist_nxt = (d > (TAW - 6)'(MAX_DISTANCE_M)) ? MAX_DISTANCE_M : d[24:0];
  end

  always_ff @(posedge clk) begin
    if (en) dist_r <= dist_nxt;
  end

  always_comb begin
    res.vld    = side_r[LAT].vld;
    res.armed  = side_r[LAT].armed;
    res.dist_m = dist_r;
  end

endmodule

FILE: src/haversine_geofence_classifier.sv
// ----------------------------------------------------------------------------
// haversine_geofence_classifier: great-circle distance and geofence alarm
// Takes two positions in microdegrees, works out the haversine distance in
// whole metres and grades it against the near and far limits when armed.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_stall     in_armed, in_last_lat, in_last_lng,
//                                    in_cur_lat, in_cur_lng
//   out      out_valid / out_stall   out_alarm_level, out_distance_m
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is accepted every cycle while in_stall is low; each passes
// through the unrolled rotation, square root, vectoring and divider
// stages of the datapath and then the output register. A synchronous
// reset clears the valid bits and restores the limits to 10 m and 50 m.
// When a result waits in the output register under stall, the pipeline
// holds unless its last stage is empty.
// ----------------------------------------------------------------------------
module haversine_geofence_classifier import hgc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_armed,
  input  logic signed [27:0] in_last_lat,
  input  logic signed [28:0] in_last_lng,
  input  logic signed [27:0] in_cur_lat,
  input  logic signed [28:0] in_cur_lng,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_alarm_level,
  output logic [24:0]        out_distance_m,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Configuration registers.
  logic [15:0] near_limit_r, near_limit_nxt;
  logic [15:0] far_limit_r, far_limit_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    near_limit_nxt = near_limit_r;
    far_limit_nxt  = far_limit_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NEAR_LIMIT: near_limit_nxt = cfg_data;
        REG_FAR_LIMIT:  far_limit_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_limit_r <= 16'd10;
      far_limit_r  <= 16'd50;
    end else begin
      near_limit_r <= near_limit_nxt;
      far_limit_r  <= far_limit_nxt;
    end
  end

  // Pipeline enable: moves unless a stalled result would be overwritten.
  hgc_item_t item;
  hgc_res_t  res;
  logic      en;
  logic      out_load;
  logic      out_valid_r, out_valid_nxt;

  assign out_load = !out_valid_r || !out_stall;
  assign en       = out_load || !res.vld;
  assign in_stall = !en;

  always_comb begin
    item.armed    = in_armed;
    item.last_lat = in_last_lat;
    item.last_lng = in_last_lng;
    item.cur_lat  = in_cur_lat;
    item.cur_lng  = in_cur_lng;
  end

  hgc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .item_vld (in_valid),
    .item     (item),
    .res      (res)
  );

  // Output register with the alarm grading; the far limit is tested first.
  logic [1:0]  level_r, level_nxt;
  logic [24:0] dist_r, dist_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    level_nxt     = level_r;
    dist_nxt      = dist_r;
    if (out_load) begin
      out_valid_nxt = res.vld;
      dist_nxt      = res.dist_m;
      if (res.armed && res.dist_m > 25'(far_limit_r)) level_nxt = ALARM_FAR;
      else if (res.armed && res.dist_m > 25'(near_limit_r)) level_nxt = ALARM_NEAR;
      else level_nxt = ALARM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    dist_r  <= dist_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_alarm_level = level_r;
  assign out_distance_m  = dist_r;

`ifndef NO_ASSERTIONS
  // A waiting, stalled result with a new one behind it must hold the input.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && res.vld) |-> in_stall)
    else $error("input accepted while the pipeline could not advance");

  // The far alarm is only given for a distance beyond the far limit.
  a_far_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && level_r == ALARM_FAR) |-> (dist_r > 25'(far_limit_r)))
    else $error("far alarm without a distance beyond the far limit");

  // Distances never exceed half the circumference.
  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (dist_r <= MAX_DISTANCE_M))
    else $error("distance beyond half the circumference");
`endif

endmodule
